@@ hw/rtl/channel_number_table_assert.svh @@
// Assertion macros used by the channel number table checker.
// Needs clk and rst_n in scope at the point of use.
`ifndef CHANNEL_NUMBER_TABLE_ASSERT_SVH
`define CHANNEL_NUMBER_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CHNUM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CHNUM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/chnum_pkg.sv @@
// Shared types and codes for the channel number table.
// No dependencies; imported by the table and its checker.
`default_nettype none

package chnum_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned KEY_W  = 3 * ID_W;
  localparam int unsigned VAL_W  = ID_W + 1;
  localparam int unsigned STAT_W = 3;

  localparam logic [ID_W-1:0] WILDCARD_ID = 16'hFFFF;
  localparam logic [ID_W-1:0] NO_CHANNEL  = 16'hFFFF;

  // Command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] STAT_UPDATED  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EXACT    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_WILD     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_MISS     = 3'd5;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/channel_number_table.sv @@
// Channel number table: keyed store with a sequential scan through one memory read port.
// Depends on chnum_pkg.
//
// A command is taken when start is high and busy is low; busy then stays high
// while the stored entries are scanned one per cycle through the single read
// port of the key and value memories, in insertion order. At most TABLE_DEPTH
// entries are stored. A command ends early when an add finds its exact key or
// a lookup finds an exact network match, since the scan stops there. The result
// is shown for exactly one cycle with out_valid high, in the cycle in which
// busy falls; the receiver cannot stall it, so it must take every beat. The
// table is empty after reset and needs no clearing pass: only entries below
// the fill count are ever read.
`default_nettype none

module channel_number_table
  import chnum_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_command,
  input  wire logic [ID_W-1:0]   in_service_id,
  input  wire logic [ID_W-1:0]   in_stream_id,
  input  wire logic [ID_W-1:0]   in_network_id,
  input  wire logic [ID_W-1:0]   in_channel_number,
  input  wire logic              in_visible_flag,
  output logic                   out_valid,
  output logic [STAT_W-1:0]      out_status,
  output logic [ID_W-1:0]        out_found_channel,
  output logic                   out_found_visible
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Storage
  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] val_mem [TABLE_DEPTH];

  // Control state
  state_t           state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    issue_r, issue_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    cmp_idx_r;
  logic             have_wild_r, have_wild_nxt;
  logic [VAL_W-1:0] wild_val_r, wild_val_nxt;

  // Latched command
  logic             req_cmd_r;
  logic [ID_W-1:0]  req_srv_r, req_strm_r, req_net_r, req_chan_r;
  logic             req_vis_r;

  // Read port data
  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;
  logic [AW-1:0]    rd_addr;

  // Write port
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]   out_chan_r, out_chan_nxt;
  logic              out_vis_r, out_vis_nxt;

  logic              accept;
  logic              key_hit, sid_hit, net_hit, wild_hit;
  logic [ID_W-1:0]   knet;
  logic [KEY_W-1:0]  req_key;
  logic [VAL_W-1:0]  req_val;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign rd_addr = issue_r[AW-1:0];
  assign req_key = {req_srv_r, req_strm_r, req_net_r};
  assign req_val = {req_chan_r, req_vis_r};

  // Compare the entry read in the previous cycle
  assign knet     = rd_key_r[ID_W-1:0];
  assign key_hit  = (rd_key_r == req_key);
  assign sid_hit  = (rd_key_r[KEY_W-1:ID_W] == {req_srv_r, req_strm_r});
  assign net_hit  = (knet == req_net_r);
  assign wild_hit = (knet == WILDCARD_ID) || (req_net_r == WILDCARD_ID);

  // Sequence the scan and form the result
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    have_wild_nxt  = have_wild_r;
    wild_val_nxt   = wild_val_r;
    wr_en          = 1'b0;
    wr_addr        = cmp_idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_chan_nxt   = out_chan_r;
    out_vis_nxt    = out_vis_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt     = ST_SCAN;
          issue_nxt     = '0;
          have_wild_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (pend_r && req_cmd_r == CMD_ADD && key_hit) begin
          // Update in place
          wr_en          = 1'b1;
          wr_addr        = cmp_idx_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_UPDATED;
          out_chan_nxt   = NO_CHANNEL;
          out_vis_nxt    = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (pend_r && req_cmd_r == CMD_LOOKUP && sid_hit && net_hit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_EXACT;
          out_chan_nxt   = rd_val_r[VAL_W-1:1];
          out_vis_nxt    = rd_val_r[0];
          state_nxt      = ST_IDLE;
        end else begin
          // Remember the latest wildcard candidate
          if (pend_r && req_cmd_r == CMD_LOOKUP && sid_hit && wild_hit) begin
            have_wild_nxt = 1'b1;
            wild_val_nxt  = rd_val_r;
          end
          if (!pend_r && issue_r == fill_r) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
            if (req_cmd_r == CMD_ADD) begin
              out_chan_nxt = NO_CHANNEL;
              out_vis_nxt  = 1'b1;
              if (fill_r == DEPTH_C) begin
                out_status_nxt = STAT_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = fill_r[AW-1:0];
                fill_nxt       = fill_r + CW'(1);
                out_status_nxt = STAT_INSERTED;
              end
            end else if (have_wild_r) begin
              out_status_nxt = STAT_WILD;
              out_chan_nxt   = wild_val_r[VAL_W-1:1];
              out_vis_nxt    = wild_val_r[0];
            end else begin
              out_status_nxt = STAT_MISS;
              out_chan_nxt   = NO_CHANNEL;
              out_vis_nxt    = 1'b1;
            end
          end else if (issue_r < fill_r) begin
            // Advance the read pointer
            pend_nxt  = 1'b1;
            issue_nxt = issue_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      have_wild_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      have_wild_r <= have_wild_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd_r  <= in_command;
      req_srv_r  <= in_service_id;
      req_strm_r <= in_stream_id;
      req_net_r  <= in_network_id;
      req_chan_r <= in_channel_number;
      req_vis_r  <= in_visible_flag;
    end
    cmp_idx_r    <= rd_addr;
    wild_val_r   <= wild_val_nxt;
    out_status_r <= out_status_nxt;
    out_chan_r   <= out_chan_nxt;
    out_vis_r    <= out_vis_nxt;
  end

  // Key and value memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= req_key;
      val_mem[wr_addr] <= req_val;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_channel = out_chan_r;
  assign out_found_visible = out_vis_r;

endmodule

`default_nettype wire

@@ hw/rtl/chnum_checker.sv @@
// Port-level checker for the channel number table, bound into channel_number_table.
// Depends on chnum_pkg and channel_number_table_assert.svh.
`default_nettype none

`include "channel_number_table_assert.svh"

module chnum_checker
  import chnum_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic [ID_W-1:0]   out_found_channel,
  input wire logic              out_found_visible
);

  logic no_data_status;

  // Statuses that carry no stored channel
  assign no_data_status = (out_status == STAT_INSERTED) || (out_status == STAT_UPDATED) ||
                          (out_status == STAT_FULL) || (out_status == STAT_MISS);

  // An accepted beat keeps the block busy in the next cycle
  `CHNUM_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy not raised after start")

  // A result beat appears only once the block has gone idle, and lasts one cycle
  `CHNUM_ASSERT_NOW(a_result_idle, out_valid, !busy, "result shown while busy")
  `CHNUM_ASSERT_NEXT(a_result_single, out_valid, !out_valid, "result held for two cycles")

  // Adds and misses report the empty channel
  `CHNUM_ASSERT_NOW(a_empty_channel, out_valid && no_data_status,
                    out_found_channel == NO_CHANNEL && out_found_visible,
                    "add or miss returned stored data")

endmodule

bind channel_number_table chnum_checker u_chnum_checker (.*);

`default_nettype wire
